FILE: hw/rtl/ops_pkg.sv
// Shared types and constants of the orbit position stepper.
package ops_pkg;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 2;
    localparam int POS_W = 20;
    localparam int PROD_W = 36;
    localparam int OPND_W = 18;

    localparam logic [CFG_INDEX_W-1:0] REG_ORBIT_RADIUS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ORBIT_RATE = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ORBIT_TILT = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPIN_RATE = 2'd3;

    localparam logic signed [POS_W:0] POS_MAX = 21'sd524287;
    localparam logic signed [POS_W:0] POS_MIN = -21'sd524288;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATE,
        S_PHASE,
        S_TRIG,
        S_MUL1,
        S_MUL2,
        S_WRITE
    } state_t;

    typedef struct packed {
        logic load_in;
        logic step_rate;
        logic step_phase;
        logic step_trig;
        logic step_mul1;
        logic step_mul2;
        logic commit;
    } cmd_t;

endpackage

FILE: hw/rtl/ops_datapath.sv
// Datapath of the orbit position stepper: registers, phase accumulators, sine table, multipliers.
module ops_datapath
    import ops_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cmd_t                          cmd,
    input  logic                          cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    input  logic [15:0]                   delta_time,
    input  logic                          has_parent,
    input  logic signed [POS_W-1:0]       parent_x,
    input  logic signed [POS_W-1:0]       parent_y,
    input  logic signed [POS_W-1:0]       parent_z,
    output logic signed [POS_W-1:0]       pos_x,
    output logic signed [POS_W-1:0]       pos_y,
    output logic signed [POS_W-1:0]       pos_z,
    output logic [15:0]                   orbit_phase_out,
    output logic [15:0]                   spin_phase_out
);

    localparam int QSH = PHASE_BITS - 2;
    localparam int SH = 28 - PHASE_BITS;
    localparam int IW = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SW = QSH + IW;

    // Sine table, built at elaboration.
    function automatic logic [15:0] rom_entry(input int k);
        logic [63:0] u;
        logic [63:0] w;
        logic [63:0] t;
        u = (64'(k) << 16) / SINE_TABLE_DEPTH;
        w = (u * u) >> 16;
        t = 64'd5223 - ((w * 64'd307) >> 16);
        t = 64'd42334 - ((w * t) >> 16);
        t = 64'd102944 - ((w * t) >> 16);
        t = (u * t) >> 16;
        t = (t + 64'd1) >> 1;
        if (t > 64'd32768)
        begin
            t = 64'd32768;
        end
        return t[15:0];
    endfunction

    logic [15:0] sine_rom [SINE_TABLE_DEPTH+1];

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++)
    begin : g_rom
        assign sine_rom[k] = rom_entry(k);
    end

    function automatic logic signed [16:0] sine_of(input logic [PHASE_BITS-1:0] ph);
        logic [1:0]      q;
        logic [QSH-1:0]  rest;
        logic [SW-1:0]   scaled;
        logic [IW-1:0]   idx;
        logic [16:0]     mag;
        q = ph[PHASE_BITS-1:PHASE_BITS-2];
        rest = ph[QSH-1:0];
        scaled = SW'(rest) * SW'(SINE_TABLE_DEPTH);
        idx = scaled[SW-1:QSH];
        if (q[0])
        begin
            idx = IW'(SINE_TABLE_DEPTH) - idx;
        end
        mag = {1'b0, sine_rom[idx]};
        return q[1] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [OPND_W-1:0] round_q15(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + PROD_W'(16384);
        return $signed(s[OPND_W+14:15]);
    endfunction

    function automatic logic [PHASE_BITS-1:0] inc_of(input logic signed [PROD_W-1:0] p);
        logic [PROD_W-1:0] s;
        s = p + (PROD_W'(1) << (SH - 1));
        return s[SH+PHASE_BITS-1:SH];
    endfunction

    function automatic logic signed [POS_W-1:0] sat_add(input logic signed [OPND_W-1:0] off,
                                                         input logic signed [POS_W-1:0] base);
        logic signed [POS_W:0] sum;
        sum = (POS_W+1)'(off) + (POS_W+1)'(base);
        if (sum > POS_MAX)
        begin
            sum = POS_MAX;
        end
        else if (sum < POS_MIN)
        begin
            sum = POS_MIN;
        end
        return sum[POS_W-1:0];
    endfunction

    // Configuration registers.
    logic [15:0]        radius_reg;
    logic signed [15:0] orbit_rate_reg;
    logic [15:0]        tilt_reg;
    logic signed [15:0] spin_rate_reg;

    // Architectural state.
    logic [PHASE_BITS-1:0] orbit_phase_reg;
    logic [PHASE_BITS-1:0] spin_phase_reg;
    logic signed [POS_W-1:0] position_x_reg;
    logic signed [POS_W-1:0] position_y_reg;
    logic signed [POS_W-1:0] position_z_reg;
    logic [15:0] orbit_out_reg;
    logic [15:0] spin_out_reg;

    // Working registers.
    logic [15:0]              dt_reg;
    logic                     has_parent_reg;
    logic signed [POS_W-1:0]  parent_x_reg;
    logic signed [POS_W-1:0]  parent_y_reg;
    logic signed [POS_W-1:0]  parent_z_reg;
    logic signed [PROD_W-1:0] prod_a_reg;
    logic signed [PROD_W-1:0] prod_b_reg;
    logic signed [16:0]       st_reg;
    logic signed [16:0]       sa_reg;
    logic signed [16:0]       ca_reg;
    logic signed [OPND_W-1:0] rs_reg;
    logic signed [OPND_W-1:0] ox_reg;
    logic signed [OPND_W-1:0] oy_reg;

    logic signed [OPND_W-1:0] a_op1;
    logic signed [OPND_W-1:0] a_op2;
    logic signed [OPND_W-1:0] b_op1;
    logic signed [OPND_W-1:0] b_op2;
    logic signed [PROD_W-1:0] prod_a_next;
    logic signed [PROD_W-1:0] prod_b_next;
    logic [PHASE_BITS-1:0]    tilt_phase;
    logic [PHASE_BITS+15:0]   tilt_wide;
    logic [PHASE_BITS+15:0]   orbit_wide;
    logic [PHASE_BITS+15:0]   spin_wide;
    logic signed [POS_W-1:0]  base_x;
    logic signed [POS_W-1:0]  base_y;
    logic signed [POS_W-1:0]  base_z;
    logic signed [POS_W-1:0]  new_x;
    logic signed [POS_W-1:0]  new_y;
    logic signed [POS_W-1:0]  new_z;

    assign tilt_wide = {tilt_reg, PHASE_BITS'(0)};
    assign tilt_phase = tilt_wide[PHASE_BITS+15:16];
    assign orbit_wide = {orbit_phase_reg, 16'd0};
    assign spin_wide = {spin_phase_reg, 16'd0};

    always_comb
    begin
        a_op1 = OPND_W'(orbit_rate_reg);
        a_op2 = $signed({2'b00, dt_reg});
        b_op1 = OPND_W'(spin_rate_reg);
        b_op2 = $signed({2'b00, dt_reg});
        if (cmd.step_phase)
        begin
            a_op1 = $signed({2'b00, radius_reg});
            a_op2 = OPND_W'(st_reg);
        end
        else if (cmd.step_mul1)
        begin
            a_op1 = $signed({2'b00, radius_reg});
            a_op2 = OPND_W'(ca_reg);
            b_op1 = rs_reg;
            b_op2 = OPND_W'(sa_reg);
        end
        else if (cmd.step_mul2)
        begin
            a_op1 = $signed({2'b00, radius_reg});
            a_op2 = OPND_W'(sa_reg);
        end
    end

    assign prod_a_next = a_op1 * a_op2;
    assign prod_b_next = b_op1 * b_op2;

    assign base_x = has_parent_reg ? parent_x_reg : '0;
    assign base_y = has_parent_reg ? parent_y_reg : '0;
    assign base_z = has_parent_reg ? parent_z_reg : '0;
    assign new_x = sat_add(ox_reg, base_x);
    assign new_y = sat_add(oy_reg, base_y);
    assign new_z = sat_add(round_q15(prod_a_reg), base_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= '0;
            orbit_rate_reg <= '0;
            tilt_reg <= '0;
            spin_rate_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ORBIT_RADIUS: radius_reg <= cfg_data;
                REG_ORBIT_RATE:   orbit_rate_reg <= $signed(cfg_data);
                REG_ORBIT_TILT:   tilt_reg <= cfg_data;
                REG_SPIN_RATE:    spin_rate_reg <= $signed(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orbit_phase_reg <= '0;
            spin_phase_reg <= '0;
            position_x_reg <= '0;
            position_y_reg <= '0;
            position_z_reg <= '0;
            orbit_out_reg <= '0;
            spin_out_reg <= '0;
        end
        else
        begin
            if (cmd.step_phase)
            begin
                orbit_phase_reg <= orbit_phase_reg + inc_of(prod_a_reg);
                spin_phase_reg <= spin_phase_reg + inc_of(prod_b_reg);
            end
            if (cmd.commit)
            begin
                orbit_out_reg <= orbit_wide[PHASE_BITS+15:PHASE_BITS];
                spin_out_reg <= spin_wide[PHASE_BITS+15:PHASE_BITS];
                if (radius_reg != '0)
                begin
                    position_x_reg <= new_x;
                    position_y_reg <= new_y;
                    position_z_reg <= new_z;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            dt_reg <= delta_time;
            has_parent_reg <= has_parent;
            parent_x_reg <= parent_x;
            parent_y_reg <= parent_y;
            parent_z_reg <= parent_z;
        end
        if (cmd.step_rate || cmd.step_phase || cmd.step_mul1 || cmd.step_mul2)
        begin
            prod_a_reg <= prod_a_next;
        end
        if (cmd.step_rate || cmd.step_mul1)
        begin
            prod_b_reg <= prod_b_next;
        end
        if (cmd.step_rate)
        begin
            st_reg <= sine_of(tilt_phase);
        end
        if (cmd.step_trig)
        begin
            sa_reg <= sine_of(orbit_phase_reg);
            ca_reg <= sine_of(orbit_phase_reg + (PHASE_BITS'(1) << QSH));
            rs_reg <= round_q15(prod_a_reg);
        end
        if (cmd.step_mul2)
        begin
            ox_reg <= round_q15(prod_a_reg);
            oy_reg <= round_q15(prod_b_reg);
        end
    end

    assign pos_x = position_x_reg;
    assign pos_y = position_y_reg;
    assign pos_z = position_z_reg;
    assign orbit_phase_out = orbit_out_reg;
    assign spin_phase_out = spin_out_reg;

endmodule

FILE: hw/rtl/ops_controller.sv
// Controller of the orbit position stepper: sequences one request through the datapath.
module ops_controller
    import ops_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next = S_RATE;
                end
            end
            S_RATE:
            begin
                cmd.step_rate = 1'b1;
                state_next = S_PHASE;
            end
            S_PHASE:
            begin
                cmd.step_phase = 1'b1;
                state_next = S_TRIG;
            end
            S_TRIG:
            begin
                cmd.step_trig = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.step_mul1 = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.step_mul2 = 1'b1;
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg)
        else $error("committed result not presented");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_RATE))
        else $error("accepted request did not start the sequence");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg)
        else $error("pending result dropped");

    a_rise_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_WRITE))
        else $error("result appeared outside the write step");

endmodule

FILE: hw/rtl/orbit_position_stepper.sv
// Top level of the orbit position stepper.
// Usage: write the radius, orbit rate, tilt and spin rate registers through the cfg_wr_en,
// cfg_index and cfg_data port while no request is in flight; each write takes effect at once.
// Each input request carries delta_time and an optional parent position (has_parent,
// parent_x, parent_y, parent_z) on a valid/ready channel. The block advances the orbit and
// spin phases and, for a nonzero radius, moves the body on its tilted orbit; the result
// carries the saturated position and both phases on a second valid/ready channel.
// out_valid rises after the request has passed the six sequencing steps rate, phase, trig,
// mul1, mul2 and write, the write step waiting while the earlier result is not yet taken.
// New requests are taken only in idle; the steps are set by the product chain radius times
// tilt sine times orbit sine running through two shared multipliers after the table lookups.
// A finished result waits in the output registers while the next request is accepted and
// processed; if it is still not taken, the block holds the new result until it is.
// Reset zeroes the config registers, both phases and the position, with no output pending.
module orbit_position_stepper
    import ops_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    parameter int SINE_TABLE_DEPTH = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [15:0]             delta_time,
    input  logic                    has_parent,
    input  logic signed [POS_W-1:0] parent_x,
    input  logic signed [POS_W-1:0] parent_y,
    input  logic signed [POS_W-1:0] parent_z,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [POS_W-1:0] pos_x,
    output logic signed [POS_W-1:0] pos_y,
    output logic signed [POS_W-1:0] pos_z,
    output logic [15:0]             orbit_phase_out,
    output logic [15:0]             spin_phase_out
);

    cmd_t cmd;

    ops_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    ops_datapath #(
        .PHASE_BITS       (PHASE_BITS),
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .delta_time      (delta_time),
        .has_parent      (has_parent),
        .parent_x        (parent_x),
        .parent_y        (parent_y),
        .parent_z        (parent_z),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .orbit_phase_out (orbit_phase_out),
        .spin_phase_out  (spin_phase_out)
    );

endmodule

FILE: tb/sv/tb_orbit_position_stepper.sv
// Self-checking testbench for orbit_position_stepper with a phase and position predictor.
`timescale 1ns / 1ps

module tb_orbit_position_stepper;
    import ops_pkg::*;

    localparam int CLK_HALF = 6;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE = 10;
    localparam int QUARTER_DEPTH = 256;
    localparam int RANDOM_PHASES = 12;
    localparam int TICKS_PER_PHASE = 105;
    localparam logic signed [POS_W-1:0] COORD_HI = POS_MAX[POS_W-1:0];
    localparam logic signed [POS_W-1:0] COORD_LO = POS_MIN[POS_W-1:0];

    typedef struct {
        logic [15:0]             dt;
        logic                    has_parent;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
    } tick_t;

    typedef struct {
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] z;
        logic [15:0]             orbit_ph;
        logic [15:0]             spin_ph;
    } fix_t;

    class orbit_predictor;
        longint                  quarter_wave[QUARTER_DEPTH + 1];
        logic [15:0]             radius;
        logic [15:0]             tilt;
        logic signed [15:0]      orbit_rate;
        logic signed [15:0]      spin_rate;
        logic [15:0]             orbit_turn;
        logic [15:0]             spin_angle;
        logic signed [POS_W-1:0] body_x;
        logic signed [POS_W-1:0] body_y;
        logic signed [POS_W-1:0] body_z;
        fix_t                    predicted_fixes[$];
        int                      errors;

        function new();
            longint u;
            longint w;
            longint t;
            for (int k = 0; k <= QUARTER_DEPTH; k++)
            begin
                u = (longint'(k) << 16) / QUARTER_DEPTH;
                w = (u * u) >> 16;
                t = 5223 - ((w * 307) >> 16);
                t = 42334 - ((w * t) >> 16);
                t = 102944 - ((w * t) >> 16);
                t = (u * t) >> 16;
                t = (t + 1) >> 1;
                quarter_wave[k] = (t > 32768) ? 32768 : t;
            end
            radius = '0;
            tilt = '0;
            orbit_rate = '0;
            spin_rate = '0;
            orbit_turn = '0;
            spin_angle = '0;
            body_x = '0;
            body_y = '0;
            body_z = '0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ORBIT_RADIUS: radius = val;
                REG_ORBIT_RATE:   orbit_rate = val;
                REG_ORBIT_TILT:   tilt = val;
                REG_SPIN_RATE:    spin_rate = val;
                default: ;
            endcase
        endfunction

        function longint sine_of(logic [15:0] ang);
            int     idx;
            longint v;
            idx = ang[13:6];
            v = quarter_wave[ang[14] ? QUARTER_DEPTH - idx : idx];
            return ang[15] ? -v : v;
        endfunction

        function longint scale_q15(longint a, longint b);
            return (a * b + 16384) >>> 15;
        endfunction

        function logic [15:0] advance(logic [15:0] ang, logic signed [15:0] rate,
                                      logic [15:0] dt);
            longint step;
            step = (longint'(rate) * longint'(dt) + 2048) >>> 12;
            return ang + step[15:0];
        endfunction

        function logic signed [POS_W-1:0] clamp(longint v);
            if (v > POS_MAX)
                return COORD_HI;
            if (v < POS_MIN)
                return COORD_LO;
            return v[POS_W-1:0];
        endfunction

        function void note_tick(tick_t t);
            longint sa;
            longint ca;
            longint st;
            longint ox;
            longint oy;
            longint oz;
            fix_t   f;
            orbit_turn = advance(orbit_turn, orbit_rate, t.dt);
            if (radius != 0)
            begin
                sa = sine_of(orbit_turn);
                ca = sine_of(orbit_turn + 16'h4000);
                st = sine_of(tilt);
                ox = scale_q15(radius, ca);
                oz = scale_q15(radius, sa);
                oy = scale_q15(scale_q15(radius, st), sa);
                if (t.has_parent)
                begin
                    ox += t.x;
                    oy += t.y;
                    oz += t.z;
                end
                body_x = clamp(ox);
                body_y = clamp(oy);
                body_z = clamp(oz);
            end
            spin_angle = advance(spin_angle, spin_rate, t.dt);
            f.x = body_x;
            f.y = body_y;
            f.z = body_z;
            f.orbit_ph = orbit_turn;
            f.spin_ph = spin_angle;
            predicted_fixes.push_back(f);
        endfunction

        function int pending();
            return predicted_fixes.size();
        endfunction

        function void compare(string name, longint want, longint got);
            if (want != got)
            begin
                errors++;
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_fix(fix_t got);
            fix_t want;
            if (predicted_fixes.size() == 0)
            begin
                errors++;
                $display("%0t: result with no request pending, expected none, got pos %0d %0d %0d",
                         $time, got.x, got.y, got.z);
                return;
            end
            want = predicted_fixes.pop_front();
            compare("pos_x", want.x, got.x);
            compare("pos_y", want.y, got.y);
            compare("pos_z", want.z, got.z);
            compare("orbit_phase_out", want.orbit_ph, got.orbit_ph);
            compare("spin_phase_out", want.spin_ph, got.spin_ph);
        endfunction
    endclass

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic [15:0]             delta_time = '0;
    logic                    has_parent = 1'b0;
    logic signed [POS_W-1:0] parent_x = '0;
    logic signed [POS_W-1:0] parent_y = '0;
    logic signed [POS_W-1:0] parent_z = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [15:0]             orbit_phase_out;
    logic [15:0]             spin_phase_out;

    orbit_predictor pred;
    bit             idling = 1'b1;
    int             stall_left = 0;
    int             quiet = 0;

    orbit_position_stepper dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .delta_time      (delta_time),
        .has_parent      (has_parent),
        .parent_x        (parent_x),
        .parent_y        (parent_y),
        .parent_z        (parent_z),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .orbit_phase_out (orbit_phase_out),
        .spin_phase_out  (spin_phase_out)
    );

    always #(CLK_HALF) clk = ~clk;

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left--;
            out_ready <= (stall_left == 0);
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 15);
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        tick_t t;
        fix_t  f;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                t.dt = delta_time;
                t.has_parent = has_parent;
                t.x = parent_x;
                t.y = parent_y;
                t.z = parent_z;
                pred.note_tick(t);
            end
            if (out_valid && out_ready)
            begin
                f.x = pos_x;
                f.y = pos_y;
                f.z = pos_z;
                f.orbit_ph = orbit_phase_out;
                f.spin_ph = spin_phase_out;
                pred.check_fix(f);
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
                if (quiet >= QUIET_LIMIT)
                begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    function automatic tick_t make_tick(logic [15:0] dt, logic hp, logic signed [POS_W-1:0] x,
                                        logic signed [POS_W-1:0] y,
                                        logic signed [POS_W-1:0] z);
        tick_t t;
        t.dt = dt;
        t.has_parent = hp;
        t.x = x;
        t.y = y;
        t.z = z;
        return t;
    endfunction

    function automatic logic signed [POS_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0: return COORD_HI;
            1: return COORD_LO;
            2: return POS_W'($urandom_range(0, 2047)) - POS_W'(1024);
            default: return POS_W'($urandom);
        endcase
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        case ($urandom_range(0, 7))
            0: t.dt = 16'h0000;
            1: t.dt = 16'hFFFF;
            2: t.dt = 16'($urandom_range(1, 255));
            default: t.dt = 16'($urandom);
        endcase
        t.has_parent = 1'($urandom);
        t.x = random_coord();
        t.y = random_coord();
        t.z = random_coord();
        return t;
    endfunction

    function automatic logic [15:0] random_reg();
        case ($urandom_range(0, 5))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'h8000;
            3: return 16'h7FFF;
            4: return 16'($urandom_range(1, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        pred.write_reg(idx, val);
    endtask

    task automatic wait_drained();
        while (pred.pending() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Registers change only once every pending request has produced its result.
    task automatic program_orbit(input logic [15:0] radius, input logic [15:0] orate,
                                 input logic [15:0] tilt, input logic [15:0] srate);
        wait_drained();
        write_reg(REG_ORBIT_RADIUS, radius);
        write_reg(REG_ORBIT_RATE, orate);
        write_reg(REG_ORBIT_TILT, tilt);
        write_reg(REG_SPIN_RATE, srate);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_tick(input tick_t t);
        in_valid <= 1'b1;
        delta_time <= t.dt;
        has_parent <= t.has_parent;
        parent_x <= t.x;
        parent_y <= t.y;
        parent_z <= t.z;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (idling && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    task automatic end_requests();
        in_valid <= 1'b0;
    endtask

    initial
    begin
        pred = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all registers at reset the position stays at the origin.
        send_tick(make_tick(16'h0000, 1'b0, '0, '0, '0));
        send_tick(make_tick(16'hFFFF, 1'b1, COORD_HI, COORD_HI, COORD_HI));
        end_requests();

        // One turn per second, so each step lands on a known quadrant.
        program_orbit(16'hFFFF, 16'h1000, 16'h4000, 16'h8000);
        send_tick(make_tick(16'h1000, 1'b1, COORD_HI, COORD_HI, COORD_HI));
        send_tick(make_tick(16'h8000, 1'b1, COORD_LO, COORD_LO, COORD_LO));
        send_tick(make_tick(16'h0000, 1'b0, COORD_HI, COORD_LO, COORD_HI));
        send_tick(make_tick(16'h4000, 1'b1, '0, '0, '0));
        end_requests();

        program_orbit(16'hFFFF, 16'h7FFF, 16'hC000, 16'h7FFF);
        send_tick(make_tick(16'hFFFF, 1'b0, '0, '0, '0));
        send_tick(make_tick(16'h0001, 1'b1, random_coord(), random_coord(), random_coord()));
        send_tick(make_tick(16'hFFFF, 1'b1, random_coord(), random_coord(), random_coord()));
        end_requests();

        program_orbit(16'h0001, 16'h8000, 16'hFFFF, 16'h0000);
        send_tick(make_tick(16'hFFFF, 1'b1, COORD_LO, COORD_HI, COORD_LO));
        send_tick(make_tick(16'h1234, 1'b1, random_coord(), random_coord(), random_coord()));
        end_requests();

        // A zero radius freezes the position while the orbit phase moves backward and the spin phase forward.
        program_orbit(16'h0000, 16'hFFFF, 16'h2000, 16'h0001);
        send_tick(make_tick(16'hFFFF, 1'b1, COORD_HI, COORD_HI, COORD_HI));
        send_tick(make_tick(16'h00FF, 1'b1, COORD_LO, COORD_LO, COORD_LO));
        end_requests();

        program_orbit(16'h8000, 16'h1000, 16'h0000, 16'h1000);
        repeat (4) send_tick(make_tick(16'h4000, 1'b0, '0, '0, '0));
        end_requests();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            idling <= (ph % 3 != 2) && (ph != RANDOM_PHASES - 1);
            program_orbit(random_reg(), random_reg(), random_reg(), random_reg());
            repeat (TICKS_PER_PHASE) send_tick(random_tick());
            end_requests();
        end

        wait_drained();
        if (pred.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
